FILE: rtl/msa_pkg.sv
// Shared types and codes for the partitioned multi-stack memory.
`timescale 1ns / 1ps

package msa_pkg;

   localparam int unsigned DATA_W    = 32;
   localparam int unsigned INDEX_W   = 3;
   localparam int unsigned NUM_SLOTS = 2 ** INDEX_W;
   localparam int unsigned CSR_W     = 4;

   typedef enum logic [1:0] {
      ACT_PUSH = 2'd0,
      ACT_POP  = 2'd1,
      ACT_SHOW = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_BAD_INDEX = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECODE,
      S_SHOW
   } state_type;

   typedef struct packed {
      logic [1:0]                action;
      logic [INDEX_W-1:0]        stack_index;
      logic signed [DATA_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  data;
      logic [1:0]                status;
      logic                      last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic       capture;    // latch the request
      logic       push;       // write element, bump fill
      logic       read_top;   // read top element, load walk pointer
      logic       read_next;  // read next element down
      logic       pop;        // drop fill by one
      logic       emit;       // present a result next cycle
      status_type emit_status;
      logic       emit_last;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      action_type action;
      logic       bad;
      logic       full;
      logic       empty;
      logic       fill_one;
      logic       remain_one;
   } sts_type;

endpackage

FILE: rtl/msa_ctrl.sv
// Sequencer for the multi-stack block: decodes each request and walks displays.
`timescale 1ns / 1ps

module msa_ctrl
   import msa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.emit_status = ST_OK;
      busy            = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_IDLE;
            if (sts.action == ACT_NONE) begin
               // no action: dropped silently
            end else if (sts.bad) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = ST_BAD_INDEX;
               cmd.emit_last   = 1'b1;
            end else if (sts.action == ACT_PUSH) begin
               if (sts.full) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = ST_OVERFLOW;
                  cmd.emit_last   = 1'b1;
               end else begin
                  cmd.push = 1'b1;
               end
            end else if (sts.empty) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = ST_UNDERFLOW;
               cmd.emit_last   = 1'b1;
            end else if (sts.action == ACT_POP) begin
               cmd.read_top  = 1'b1;
               cmd.pop       = 1'b1;
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
            end else begin
               cmd.read_top  = 1'b1;
               cmd.emit      = 1'b1;
               cmd.emit_last = sts.fill_one;
               if (!sts.fill_one) begin
                  state_in = S_SHOW;
               end
            end
         end
         S_SHOW: begin
            cmd.read_next = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_last = sts.remain_one;
            if (sts.remain_one) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/msa_dp.sv
// Datapath: partition bounds, fill counters, element memory and result register.
`timescale 1ns / 1ps

module msa_dp
   import msa_pkg::*;
#(
   parameter int unsigned MEM_DEPTH  = 32,
   parameter int unsigned MAX_STACKS = 8
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata,
   input  req_type          req_item,
   input  cmd_type          cmd,
   output sts_type          sts,
   output logic             rsp_valid,
   output rsp_type          rsp_item
);

   localparam int unsigned AW  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int unsigned FW  = $clog2(MEM_DEPTH + 1);
   localparam int unsigned NW  = $clog2(MAX_STACKS + 1);
   localparam int unsigned CW  = (NW > INDEX_W) ? NW : INDEX_W;
   localparam int unsigned EW  = (NW > CSR_W) ? NW : CSR_W;
   localparam int unsigned PW  = FW + INDEX_W;

   // partition size for each stack count, worked out at elaboration
   logic [FW-1:0] part_tab [2**NW];
   for (genvar k = 0; k < 2**NW; k++) begin : g_part
      if (k == 0) begin : g_zero
         assign part_tab[k] = '0;
      end else begin : g_div
         localparam int unsigned PART = MEM_DEPTH / k;
         assign part_tab[k] = FW'(PART);
      end
   end

   logic [NW-1:0]            nstk_ff;
   logic [FW-1:0]            part_ff;
   logic [FW-1:0]            fill_ff [NUM_SLOTS];
   logic [DATA_W-1:0]        mem [MEM_DEPTH];
   req_type                  req_ff;
   logic [AW-1:0]            addr_ff;
   logic [FW-1:0]            remain_ff;
   logic signed [DATA_W-1:0] rd_data_ff;
   logic                     rsp_valid_ff;
   logic [1:0]               rsp_status_ff;
   logic                     rsp_last_ff;

   logic [EW-1:0]  csr_ext;
   logic [NW-1:0]  nstk_in;
   logic [FW-1:0]  fill;
   logic [PW-1:0]  prod;
   logic [FW:0]    base_w;
   logic [FW:0]    fill_w;
   logic [FW:0]    cap;
   logic [FW:0]    push_sum;
   logic [FW:0]    top_sum;
   logic           last_part;

   // effective stack count: zero acts as one, clamped to MAX_STACKS
   always_comb begin
      csr_ext = EW'(csr_wdata);
      if (csr_ext == '0) begin
         nstk_in = NW'(1);
      end else if (csr_ext > EW'(MAX_STACKS)) begin
         nstk_in = NW'(MAX_STACKS);
      end else begin
         nstk_in = NW'(csr_ext);
      end
   end

   always_comb begin
      fill      = fill_ff[req_ff.stack_index];
      prod      = PW'(part_ff) * PW'(req_ff.stack_index);
      base_w    = (FW+1)'(prod[AW-1:0]);
      fill_w    = (FW+1)'(fill);
      last_part = (CW'(req_ff.stack_index) + CW'(1)) >= CW'(nstk_ff);
      cap       = last_part ? ((FW+1)'(MEM_DEPTH) - base_w) : (FW+1)'(part_ff);
      push_sum  = base_w + fill_w;
      top_sum   = push_sum - (FW+1)'(1);

      sts.action     = action_type'(req_ff.action);
      sts.bad        = CW'(req_ff.stack_index) >= CW'(nstk_ff);
      sts.full       = fill_w >= cap;
      sts.empty      = (fill == '0);
      sts.fill_one   = (fill == FW'(1));
      sts.remain_one = (remain_ff == FW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nstk_ff <= NW'(1);
         part_ff <= part_tab[NW'(1)];
         for (int i = 0; i < NUM_SLOTS; i++) begin
            fill_ff[i] <= '0;
         end
      end else if (csr_we) begin
         // new split empties every stack
         nstk_ff <= nstk_in;
         part_ff <= part_tab[nstk_in];
         for (int i = 0; i < NUM_SLOTS; i++) begin
            fill_ff[i] <= '0;
         end
      end else if (cmd.push) begin
         fill_ff[req_ff.stack_index] <= fill + FW'(1);
      end else if (cmd.pop) begin
         fill_ff[req_ff.stack_index] <= fill - FW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_item;
      end
      if (cmd.push) begin
         mem[push_sum[AW-1:0]] <= req_ff.value;
      end
      if (cmd.read_top) begin
         rd_data_ff <= mem[top_sum[AW-1:0]];
         addr_ff    <= top_sum[AW-1:0] - AW'(1);
         remain_ff  <= fill - FW'(1);
      end else if (cmd.read_next) begin
         rd_data_ff <= mem[addr_ff];
         addr_ff    <= addr_ff - AW'(1);
         remain_ff  <= remain_ff - FW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
      if (cmd.emit) begin
         rsp_status_ff <= cmd.emit_status;
         rsp_last_ff   <= cmd.emit_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_item.data   = (rsp_status_ff == ST_OK) ? rd_data_ff : '0;
   assign rsp_item.status = rsp_status_ff;
   assign rsp_item.last   = rsp_last_ff;

endmodule

FILE: rtl/multiple_stacks_in_one_array.sv
// Top level: several stacks sharing one element memory with a fixed split.
`timescale 1ns / 1ps

// A request transfers when start is high and busy is low; busy is high while
// the block works on it. A push, a pop or an error keeps busy high only while
// the request is decoded, so the next request can transfer once busy falls;
// any result is valid in the first cycle with busy low. A display of a stack
// holding F elements holds busy while reading, gives one result per cycle,
// top first, each registered from its read, the last in the first cycle with
// busy low, as the single read port of the element memory walks down the
// partition. Each result is on rsp_item for one cycle with rsp_valid high and
// cannot be held off. csr_wdata sets the stack count (zero acts as one,
// anything above MAX_STACKS as MAX_STACKS); writing it empties every stack.
module multiple_stacks_in_one_array
   import msa_pkg::*;
#(
   parameter int unsigned MEM_DEPTH  = 32,
   parameter int unsigned MAX_STACKS = 8
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_item,
   output logic             rsp_valid,
   output rsp_type          rsp_item,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   msa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   msa_dp #(
      .MEM_DEPTH  (MEM_DEPTH),
      .MAX_STACKS (MAX_STACKS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_item  (req_item),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

FILE: test/tb_multiple_stacks_in_one_array.sv
// Testbench for multiple_stacks_in_one_array: directed and random stack operations, self-checked.
`timescale 1ns / 1ps

module tb_multiple_stacks_in_one_array;
   import msa_pkg::*;

   localparam int unsigned MEM_DEPTH     = 32;
   localparam int unsigned MAX_STACKS    = 8;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT   = 200000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   req_type          req_item = '0;
   logic             rsp_valid;
   rsp_type          rsp_item;
   logic             csr_we = 1'b0;
   logic [CSR_W-1:0] csr_wdata = '0;

   // own copy of the block's state
   logic [DATA_W-1:0] stack_words [MEM_DEPTH];
   int unsigned       stack_fill  [MAX_STACKS];
   int unsigned       stack_base  [MAX_STACKS];
   logic [CSR_W-1:0]  stack_count_reg;

   req_type     pend_q [$];
   rsp_type     stack_results_q [$];
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   int unsigned idle_left = 0;
   bit          quiet = 1'b0;

   multiple_stacks_in_one_array #(
      .MEM_DEPTH  (MEM_DEPTH),
      .MAX_STACKS (MAX_STACKS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned live_stacks();
      if (stack_count_reg == 0) return 1;
      if (stack_count_reg > MAX_STACKS) return MAX_STACKS;
      return 32'(stack_count_reg);
   endfunction

   // new stack count: rebuild the split, empty every stack
   function automatic void set_stack_count(input logic [CSR_W-1:0] v);
      int unsigned n;
      int unsigned part;
      stack_count_reg = v;
      n = live_stacks();
      part = MEM_DEPTH / n;
      for (int k = 0; k < MAX_STACKS; k++) begin
         stack_base[k] = (k < n) ? part * k : 0;
         stack_fill[k] = 0;
      end
   endfunction

   function automatic void expect_rsp(input logic [DATA_W-1:0] d, input status_type st,
                                      input logic lst);
      rsp_type e;
      e.data   = d;
      e.status = st;
      e.last   = lst;
      stack_results_q.push_back(e);
   endfunction

   function automatic void model_stack_op(input req_type r);
      int unsigned n;
      int unsigned s;
      int unsigned fill;
      int unsigned base;
      int unsigned room;
      n = live_stacks();
      s = 32'(r.stack_index);
      if (r.action == ACT_NONE) return;
      if (s >= n) begin
         expect_rsp('0, ST_BAD_INDEX, 1'b1);
         return;
      end
      fill = stack_fill[s];
      base = stack_base[s];
      if (r.action == ACT_PUSH) begin
         room = (s + 1 >= n) ? MEM_DEPTH - base : stack_base[s + 1] - base;
         if (fill >= room) begin
            expect_rsp('0, ST_OVERFLOW, 1'b1);
         end else begin
            stack_words[(base + fill) % MEM_DEPTH] = r.value;
            stack_fill[s] = fill + 1;
         end
         return;
      end
      if (fill == 0) begin
         expect_rsp('0, ST_UNDERFLOW, 1'b1);
         return;
      end
      if (r.action == ACT_POP) begin
         expect_rsp(stack_words[(base + fill - 1) % MEM_DEPTH], ST_OK, 1'b1);
         stack_fill[s] = fill - 1;
         return;
      end
      // display walks top to bottom
      for (int k = 0; k < fill; k++)
         expect_rsp(stack_words[(base + fill - 1 - k) % MEM_DEPTH], ST_OK, k + 1 == fill);
   endfunction

   task automatic note_mismatch(input string what, input logic [DATA_W-1:0] got,
                                input logic [DATA_W-1:0] want);
      $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
      mismatches++;
   endtask

   // driver: one transfer per accepted item, random idle bursts in between
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         idle_left = 0;
      end else begin
         if (start && !busy) begin
            model_stack_op(req_item);
            void'(pend_q.pop_front());
            if (!quiet && $urandom_range(0, 3) == 0) idle_left = $urandom_range(1, 14);
         end
         if (start && busy) begin
            // hold the item until it transfers
         end else if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (pend_q.size() > 0) begin
            start    <= 1'b1;
            req_item <= pend_q[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (stack_results_q.size() == 0) begin
            note_mismatch("unexpected result", rsp_item.data, '0);
         end else begin
            want = stack_results_q.pop_front();
            if (rsp_item.data !== want.data) note_mismatch("data", rsp_item.data, want.data);
            if (rsp_item.status !== want.status)
               note_mismatch("status", DATA_W'(rsp_item.status), DATA_W'(want.status));
            if (rsp_item.last !== want.last)
               note_mismatch("last", DATA_W'(rsp_item.last), DATA_W'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic void queue_op(input action_type act, input int unsigned idx,
                                    input logic [DATA_W-1:0] v);
      req_type r;
      r.action      = act;
      r.stack_index = INDEX_W'(idx);
      r.value       = v;
      pend_q.push_back(r);
   endfunction

   task automatic drain();
      do @(posedge clock);
      while (pend_q.size() != 0 || start || busy || stack_results_q.size() != 0);
      // a trailing push gives no result but may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_stack_count(input logic [CSR_W-1:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      set_stack_count(v);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(input int unsigned count, input int unsigned push_pct);
      int unsigned pick;
      int unsigned idx;
      action_type  act;
      @(negedge clock);
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < push_pct) act = ACT_PUSH;
         else if (pick >= 97) act = ACT_NONE;
         else act = ($urandom_range(0, 2) == 2) ? ACT_SHOW : ACT_POP;
         if ($urandom_range(0, 9) == 0) idx = $urandom_range(0, MAX_STACKS - 1);
         else idx = $urandom_range(0, live_stacks() - 1);
         queue_op(act, idx, $urandom);
      end
      drain();
   endtask

   initial begin
      set_stack_count(CSR_W'(1));
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // one stack over the whole memory: extremes, ignored code, bad index, empty cases
      @(negedge clock);
      queue_op(ACT_PUSH, 0, 32'h7FFF_FFFF);
      queue_op(ACT_PUSH, 0, 32'h8000_0000);
      queue_op(ACT_PUSH, 0, 32'h0000_0000);
      queue_op(ACT_PUSH, 0, 32'hFFFF_FFFF);
      queue_op(ACT_SHOW, 0, '0);
      queue_op(ACT_POP,  0, '0);
      queue_op(ACT_NONE, 0, 32'h1234_5678);
      queue_op(ACT_PUSH, 1, 32'hDEAD_BEEF);
      queue_op(ACT_SHOW, 7, '0);
      queue_op(ACT_POP,  0, '0);
      queue_op(ACT_POP,  0, '0);
      queue_op(ACT_POP,  0, '0);
      queue_op(ACT_POP,  0, '0);
      queue_op(ACT_SHOW, 0, '0);
      drain();

      // eight stacks of four words: overflow on the last partition
      write_stack_count(4'd8);
      @(negedge clock);
      queue_op(ACT_PUSH, 7, 32'h5555_5555);
      queue_op(ACT_PUSH, 7, 32'hAAAA_AAAA);
      queue_op(ACT_PUSH, 7, 32'h0000_0001);
      queue_op(ACT_PUSH, 7, 32'hFFFF_FFFE);
      queue_op(ACT_PUSH, 7, 32'h0F0F_0F0F);
      queue_op(ACT_SHOW, 7, '0);
      queue_op(ACT_PUSH, 0, 32'h1234_5678);
      queue_op(ACT_POP,  3, '0);
      queue_op(ACT_POP,  0, '0);
      drain();

      write_stack_count(4'd0);
      random_phase(30, 60);
      write_stack_count(4'd3);
      random_phase(30, 50);
      write_stack_count(4'd15);
      random_phase(30, 55);
      write_stack_count(4'd1);
      random_phase(35, 85);
      write_stack_count(4'd5);
      random_phase(25, 50);
      write_stack_count(4'd2);
      quiet = 1'b1;
      random_phase(30, 50);

      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
